// ----- sv/lfu_pkg.sv -----
// Shared constants, types and command codes for the LFU slot replacement block.
package lfu_pkg;

    localparam int SLOTS      = 16;
    localparam int KEY_BITS   = 8;
    localparam int COUNT_BITS = 16;
    localparam int STAMP_BITS = 32;
    localparam int CFG_BITS   = 5;
    localparam int PADDR_W    = 3;

    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W     = $clog2(SLOTS + 1);
    localparam int GROUP_SIZE = 4;
    localparam int GROUPS     = (SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int LEAVES     = 1 << SLOT_W;
    localparam int SCORE_W    = COUNT_BITS + STAMP_BITS;

    localparam logic [CFG_BITS-1:0]  SLOTS_RESET      = CFG_BITS'(16);
    localparam logic [PADDR_W-3:0]   REG_SLOTS_IN_USE = '0;

    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_LIST   = 1'b1;

    typedef logic [SCORE_W-1:0] lfu_score_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_LIST
    } lfu_state_t;

    typedef struct packed {
        logic capture;
        logic access_done;
        logic evict_done;
        logic list_emit;
    } lfu_cmd_t;

    typedef struct packed {
        logic need_evict;
        logic out_free;
        logic list_last;
    } lfu_stat_t;

endpackage

// ----- sv/lfu_ctrl.sv -----
// Controller state machine sequencing lookup, eviction and listing.
module lfu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    input  lfu_pkg::lfu_stat_t stat,
    output lfu_pkg::lfu_cmd_t  ctl
);
    import lfu_pkg::*;

    lfu_state_t state_reg;
    lfu_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_cmd == CMD_LIST) ? ST_LIST : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (stat.need_evict)
                begin
                    state_next = ST_EVICT;
                end
                else if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EVICT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                if (stat.out_free && stat.list_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        ctl.capture     = 1'b0;
        ctl.access_done = 1'b0;
        ctl.evict_done  = 1'b0;
        ctl.list_emit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            ST_LOOKUP:
            begin
                ctl.access_done = !stat.need_evict && stat.out_free;
            end
            ST_EVICT:
            begin
                ctl.evict_done = stat.out_free;
            end
            ST_LIST:
            begin
                ctl.list_emit = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/lfu_dp.sv -----
// Datapath holding the slot table, victim search, sorted listing and result register.
module lfu_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lfu_pkg::lfu_cmd_t              ctl,
    output lfu_pkg::lfu_stat_t             stat,
    input  logic [lfu_pkg::KEY_BITS-1:0]   in_key,
    input  logic [lfu_pkg::CFG_BITS-1:0]   slots_in_use,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           hit,
    output logic [lfu_pkg::SLOT_W-1:0]     slot_index,
    output logic                           evicted_valid,
    output logic [lfu_pkg::KEY_BITS-1:0]   evicted_key,
    output logic                           list_valid,
    output logic [lfu_pkg::KEY_BITS-1:0]   list_key,
    output logic                           last
);
    import lfu_pkg::*;

    localparam int CMP_W = (CFG_BITS > FILL_W) ? CFG_BITS : FILL_W;

    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [KEY_BITS-1:0]   keys_reg   [SLOTS];
    logic [KEY_BITS-1:0]   keys_next  [SLOTS];
    logic [COUNT_BITS-1:0] counts_reg [SLOTS];
    logic [COUNT_BITS-1:0] counts_next[SLOTS];
    logic [STAMP_BITS-1:0] stamps_reg [SLOTS];
    logic [STAMP_BITS-1:0] stamps_next[SLOTS];
    logic [FILL_W-1:0]     filled_reg, filled_next;
    logic [STAMP_BITS-1:0] stamp_reg, stamp_next, stamp_inc;

    logic [CMP_W-1:0]      cfg_ext;
    logic [FILL_W-1:0]     n_eff;
    logic [SLOTS-1:0]      match;
    logic [SLOTS-1:0]      cand;
    logic                  any_hit;
    logic                  key_zero;
    logic                  has_free;
    logic [SLOT_W-1:0]     hit_idx;

    logic                  grp_v_reg    [GROUPS];
    logic                  grp_v_next   [GROUPS];
    lfu_score_t            grp_score_reg [GROUPS];
    lfu_score_t            grp_score_next[GROUPS];
    logic [SLOT_W-1:0]     grp_idx_reg  [GROUPS];
    logic [SLOT_W-1:0]     grp_idx_next [GROUPS];
    logic [KEY_BITS-1:0]   grp_key_reg  [GROUPS];
    logic [KEY_BITS-1:0]   grp_key_next [GROUPS];

    logic                  vic_found;
    lfu_score_t            vic_score;
    logic [SLOT_W-1:0]     vic_idx;
    logic [KEY_BITS-1:0]   vic_key;

    logic [KEY_BITS-1:0]   list_prev_reg, list_prev_next;
    logic [FILL_W-1:0]     list_cnt_reg, list_cnt_next, list_cnt_inc;
    logic                  hv [2*LEAVES];
    logic [KEY_BITS-1:0]   hk [2*LEAVES];

    logic                  out_valid_reg, out_valid_next;
    logic                  hit_reg, hit_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic [KEY_BITS-1:0]   ev_key_reg, ev_key_next;
    logic                  list_valid_reg, list_valid_next;
    logic [KEY_BITS-1:0]   list_key_reg, list_key_next;
    logic                  last_reg, last_next;

    // Register values of zero act as one slot; values beyond the table act as the full table.
    always_comb
    begin
        cfg_ext = CMP_W'(slots_in_use);
        if (cfg_ext == '0)
        begin
            n_eff = FILL_W'(1);
        end
        else if (cfg_ext > CMP_W'(SLOTS))
        begin
            n_eff = FILL_W'(SLOTS);
        end
        else
        begin
            n_eff = FILL_W'(cfg_ext);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            match[i] = (FILL_W'(i) < filled_reg) && (keys_reg[i] == key_reg);
            cand[i]  = FILL_W'(i) < n_eff;
            if (match[i])
            begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    assign any_hit   = |match;
    assign key_zero  = (key_reg == '0);
    assign has_free  = filled_reg < n_eff;
    assign stamp_inc = (stamp_reg == '1) ? stamp_reg : stamp_reg + 1'b1;

    // First half of the victim search: the best candidate of each group of four slots.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_v_next[g]     = 1'b0;
            grp_score_next[g] = '0;
            grp_idx_next[g]   = '0;
            grp_key_next[g]   = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < SLOTS)
                begin
                    if (cand[g * GROUP_SIZE + j] &&
                        (!grp_v_next[g] ||
                         ({counts_reg[g * GROUP_SIZE + j], stamps_reg[g * GROUP_SIZE + j]}
                          < grp_score_next[g])))
                    begin
                        grp_v_next[g]     = 1'b1;
                        grp_score_next[g] = {counts_reg[g * GROUP_SIZE + j],
                                             stamps_reg[g * GROUP_SIZE + j]};
                        grp_idx_next[g]   = SLOT_W'(g * GROUP_SIZE + j);
                        grp_key_next[g]   = keys_reg[g * GROUP_SIZE + j];
                    end
                end
            end
        end
    end

    always_comb
    begin
        vic_found = 1'b0;
        vic_score = '0;
        vic_idx   = '0;
        vic_key   = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (grp_v_reg[g] && (!vic_found || (grp_score_reg[g] < vic_score)))
            begin
                vic_found = 1'b1;
                vic_score = grp_score_reg[g];
                vic_idx   = grp_idx_reg[g];
                vic_key   = grp_key_reg[g];
            end
        end
    end

    // Smallest resident key above the last one listed, through a binary tree.
    always_comb
    begin
        hv[0] = 1'b0;
        hk[0] = '0;
        for (int k = 0; k < LEAVES; k++)
        begin
            hv[LEAVES + k] = 1'b0;
            hk[LEAVES + k] = '0;
            if (k < SLOTS)
            begin
                hv[LEAVES + k] = (FILL_W'(k) < filled_reg) && (keys_reg[k] > list_prev_reg);
                hk[LEAVES + k] = keys_reg[k];
            end
        end
        for (int k = LEAVES - 1; k >= 1; k--)
        begin
            if (hv[2*k] && (!hv[2*k+1] || (hk[2*k] < hk[2*k+1])))
            begin
                hv[k] = hv[2*k];
                hk[k] = hk[2*k];
            end
            else
            begin
                hv[k] = hv[2*k+1];
                hk[k] = hk[2*k+1];
            end
        end
    end

    assign list_cnt_inc = list_cnt_reg + 1'b1;

    assign stat.need_evict = !key_zero && !any_hit && !has_free;
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.list_last  = (filled_reg == '0) || (list_cnt_inc == filled_reg);

    always_comb
    begin
        key_next        = key_reg;
        keys_next       = keys_reg;
        counts_next     = counts_reg;
        stamps_next     = stamps_reg;
        filled_next     = filled_reg;
        stamp_next      = stamp_reg;
        list_prev_next  = list_prev_reg;
        list_cnt_next   = list_cnt_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        ev_valid_next   = ev_valid_reg;
        ev_key_next     = ev_key_reg;
        list_valid_next = list_valid_reg;
        list_key_next   = list_key_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (ctl.capture)
        begin
            key_next       = in_key;
            list_prev_next = '0;
            list_cnt_next  = '0;
        end

        if (ctl.access_done || ctl.evict_done || ctl.list_emit)
        begin
            out_valid_next  = 1'b1;
            hit_next        = 1'b0;
            slot_next       = '0;
            ev_valid_next   = 1'b0;
            ev_key_next     = '0;
            list_valid_next = 1'b0;
            list_key_next   = '0;
            last_next       = 1'b1;
        end

        if (ctl.access_done && !key_zero)
        begin
            stamp_next = stamp_inc;
            if (any_hit)
            begin
                hit_next  = 1'b1;
                slot_next = hit_idx;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (match[i] && (counts_reg[i] != '1))
                    begin
                        counts_next[i] = counts_reg[i] + 1'b1;
                    end
                end
            end
            else
            begin
                slot_next   = SLOT_W'(filled_reg);
                filled_next = filled_reg + 1'b1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (FILL_W'(i) == filled_reg)
                    begin
                        keys_next[i]   = key_reg;
                        counts_next[i] = COUNT_BITS'(1);
                        stamps_next[i] = stamp_reg;
                    end
                end
            end
        end

        if (ctl.evict_done)
        begin
            stamp_next    = stamp_inc;
            slot_next     = vic_idx;
            ev_valid_next = 1'b1;
            ev_key_next   = vic_key;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (SLOT_W'(i) == vic_idx)
                begin
                    keys_next[i]   = key_reg;
                    counts_next[i] = COUNT_BITS'(1);
                    stamps_next[i] = stamp_reg;
                end
            end
        end

        if (ctl.list_emit && (filled_reg != '0))
        begin
            list_valid_next = 1'b1;
            list_key_next   = hk[1];
            last_next       = stat.list_last;
            list_prev_next  = hk[1];
            list_cnt_next   = list_cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg    <= '0;
            stamp_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            filled_reg    <= filled_next;
            stamp_reg     <= stamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        keys_reg       <= keys_next;
        counts_reg     <= counts_next;
        stamps_reg     <= stamps_next;
        grp_v_reg      <= grp_v_next;
        grp_score_reg  <= grp_score_next;
        grp_idx_reg    <= grp_idx_next;
        grp_key_reg    <= grp_key_next;
        list_prev_reg  <= list_prev_next;
        list_cnt_reg   <= list_cnt_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        ev_valid_reg   <= ev_valid_next;
        ev_key_reg     <= ev_key_next;
        list_valid_reg <= list_valid_next;
        list_key_reg   <= list_key_next;
        last_reg       <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot_index    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_key   = ev_key_reg;
    assign list_valid    = list_valid_reg;
    assign list_key      = list_key_reg;
    assign last          = last_reg;

endmodule

// ----- sv/lfu_slot_replacement.sv -----
// Top level of the LFU slot replacement block with its configuration register.
//
//   Channel  Signals                                 Transfer when
//   in       in_valid, in_ready, cmd, key            in_valid and in_ready high
//   out      out_valid, out_ready, hit .. last       out_valid and out_ready high
//   cfg      psel, penable, pwrite, paddr, pwdata    psel, penable, pwrite, pready high
//
// In an access, ST_IDLE takes the item and ST_LOOKUP does the parallel key compare
// with its commit. A miss on a full table adds ST_EVICT for the second half of the
// registered victim search. A list gives one result per cycle while the output is
// free, through the key minimum tree. Results wait in an output register, so the next
// item is taken while a result stalls. Reset empties the table at once; no sweep follows.
module lfu_slot_replacement (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lfu_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cmd,
    input  logic [lfu_pkg::KEY_BITS-1:0]   key,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hit,
    output logic [lfu_pkg::SLOT_W-1:0]     slot_index,
    output logic                           evicted_valid,
    output logic [lfu_pkg::KEY_BITS-1:0]   evicted_key,
    output logic                           list_valid,
    output logic [lfu_pkg::KEY_BITS-1:0]   list_key,
    output logic                           last
);
    import lfu_pkg::*;

    logic [CFG_BITS-1:0] slots_in_use_reg, slots_in_use_next;
    logic                reg_sel;
    lfu_cmd_t            ctrl_cmd;
    lfu_stat_t           ctrl_stat;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_SLOTS_IN_USE);
    assign prdata  = reg_sel ? 32'(slots_in_use_reg) : '0;

    always_comb
    begin
        slots_in_use_next = slots_in_use_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            slots_in_use_next = pwdata[CFG_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_RESET;
        end
        else
        begin
            slots_in_use_reg <= slots_in_use_next;
        end
    end

    lfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (cmd),
        .in_ready (in_ready),
        .stat     (ctrl_stat),
        .ctl      (ctrl_cmd)
    );

    lfu_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctrl_cmd),
        .stat          (ctrl_stat),
        .in_key        (key),
        .slots_in_use  (slots_in_use_reg),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .hit           (hit),
        .slot_index    (slot_index),
        .evicted_valid (evicted_valid),
        .evicted_key   (evicted_key),
        .list_valid    (list_valid),
        .list_key      (list_key),
        .last          (last)
    );

endmodule
